### hw/rtl/utf8s_pkg.sv
package utf8s_pkg;

  typedef enum logic [1:0] {
    StChar     = 2'd0,
    StContLead = 2'd1,
    StBadCont  = 2'd2,
    StTrunc    = 2'd3
  } status_e;

  localparam int unsigned CodeW  = 31;
  localparam int unsigned CountW = 3;
  localparam int unsigned BytesW = 48;
  localparam int unsigned MaxLen = 6;

  localparam logic [CodeW-1:0] Lim2 = 31'h0000_0800;
  localparam logic [CodeW-1:0] Lim3 = 31'h0001_0000;
  localparam logic [CodeW-1:0] Lim4 = 31'h0020_0000;
  localparam logic [CodeW-1:0] Lim5 = 31'h0400_0000;

  // decoder output towards the encoder
  typedef struct packed {
    logic             vld;
    status_e          status;
    logic [CodeW-1:0] code;
  } dec_t;

  typedef struct packed {
    status_e           status;
    logic [CodeW-1:0]  code_point;
    logic [CountW-1:0] byte_count;
    logic [BytesW-1:0] char_bytes;
  } res_t;

  function automatic logic [7:0] lead_mark(input logic [CountW-1:0] n);
    logic [7:0] m;
    case (n)
      3'd2:    m = 8'hc0;
      3'd3:    m = 8'he0;
      3'd4:    m = 8'hf0;
      3'd5:    m = 8'hf8;
      3'd6:    m = 8'hfc;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/utf8s_decode.sv
module utf8s_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_acc_i,
  input  logic [7:0]          data_byte_i,
  input  logic                eos_i,
  output utf8s_pkg::dec_t     dec_o
);

  logic [2:0]                    left_q, left_d;
  logic [utf8s_pkg::CodeW-1:0]   acc_q, acc_d;
  logic                          disc_q, disc_d;
  logic [utf8s_pkg::CodeW-1:0]   acc_sh;
  logic [2:0]                    left_dec;
  logic [2:0]                    cnt;
  logic [5:0]                    lead_bits;

  always_comb begin
    // continuation count of a lead byte (0xfe/0xff act as six-byte leads)
    if (data_byte_i >= 8'hfc) begin
      cnt = 3'd5;
      lead_bits = {5'd0, data_byte_i[0]};
    end else if (data_byte_i >= 8'hf8) begin
      cnt = 3'd4;
      lead_bits = {4'd0, data_byte_i[1:0]};
    end else if (data_byte_i >= 8'hf0) begin
      cnt = 3'd3;
      lead_bits = {3'd0, data_byte_i[2:0]};
    end else if (data_byte_i >= 8'he0) begin
      cnt = 3'd2;
      lead_bits = {2'd0, data_byte_i[3:0]};
    end else begin
      cnt = 3'd1;
      lead_bits = {1'b0, data_byte_i[4:0]};
    end
  end

  assign acc_sh   = {acc_q[utf8s_pkg::CodeW-7:0], data_byte_i[5:0]};
  assign left_dec = left_q - 3'd1;

  always_comb begin
    left_d       = left_q;
    acc_d        = acc_q;
    disc_d       = disc_q;
    dec_o.vld    = 1'b0;
    dec_o.status = utf8s_pkg::StChar;
    dec_o.code   = '0;
    if (disc_q) begin
      // dropping until the end of the string
    end else if (left_q == 3'd0) begin
      if (!data_byte_i[7]) begin
        dec_o.vld  = 1'b1;
        dec_o.code = {{(utf8s_pkg::CodeW-8){1'b0}}, data_byte_i};
      end else if (data_byte_i[7:6] == 2'b10) begin
        dec_o.vld    = 1'b1;
        dec_o.status = utf8s_pkg::StContLead;
        disc_d       = 1'b1;
      end else begin
        left_d = cnt;
        acc_d  = {{(utf8s_pkg::CodeW-6){1'b0}}, lead_bits};
        if (eos_i) begin
          dec_o.vld    = 1'b1;
          dec_o.status = utf8s_pkg::StTrunc;
        end
      end
    end else begin
      if (data_byte_i[7:6] != 2'b10) begin
        dec_o.vld    = 1'b1;
        dec_o.status = utf8s_pkg::StBadCont;
        disc_d       = 1'b1;
      end else begin
        acc_d  = acc_sh;
        left_d = left_dec;
        if (left_dec == 3'd0) begin
          dec_o.vld  = 1'b1;
          dec_o.code = acc_sh;
          acc_d      = '0;
        end else if (eos_i) begin
          dec_o.vld    = 1'b1;
          dec_o.status = utf8s_pkg::StTrunc;
        end
      end
    end
    if (eos_i) begin
      left_d = 3'd0;
      acc_d  = '0;
      disc_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
      acc_q  <= '0;
      disc_q <= 1'b0;
    end else if (in_acc_i) begin
      left_q <= left_d;
      acc_q  <= acc_d;
      disc_q <= disc_d;
    end
  end

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_i && eos_i |=> left_q == 3'd0 && !disc_q && acc_q == '0)
    else $error("state not cleared after end of string");

  a_no_result_dropping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> !dec_o.vld)
    else $error("result raised while dropping");

endmodule

### hw/rtl/utf8s_encode.sv
module utf8s_encode (
  input  utf8s_pkg::dec_t  dec_i,
  output utf8s_pkg::res_t  res_o
);

  logic [35:0]                   c36;
  logic [5:0]                    grp [utf8s_pkg::MaxLen];
  logic [utf8s_pkg::CountW-1:0]  n;
  logic [2:0]                    idx;
  logic [7:0]                    b;

  assign c36 = {5'd0, dec_i.code};

  always_comb begin
    for (int j = 0; j < utf8s_pkg::MaxLen; j++) begin
      grp[j] = c36[6*j +: 6];
    end
  end

  always_comb begin
    if (dec_i.code < 31'h80)               n = 3'd1;
    else if (dec_i.code < utf8s_pkg::Lim2) n = 3'd2;
    else if (dec_i.code < utf8s_pkg::Lim3) n = 3'd3;
    else if (dec_i.code < utf8s_pkg::Lim4) n = 3'd4;
    else if (dec_i.code < utf8s_pkg::Lim5) n = 3'd5;
    else                                   n = 3'd6;
  end

  always_comb begin
    res_o.status     = dec_i.status;
    res_o.code_point = '0;
    res_o.byte_count = '0;
    res_o.char_bytes = '0;
    idx              = 3'd0;
    b                = 8'd0;
    if (dec_i.status == utf8s_pkg::StChar) begin
      res_o.code_point = dec_i.code;
      res_o.byte_count = n;
      for (int k = 0; k < utf8s_pkg::MaxLen; k++) begin
        b = 8'd0;
        if (3'(k) < n) begin
          idx = n - 3'(k) - 3'd1;
          if (k == 0) begin
            if (n == 3'd1) b = {1'b0, dec_i.code[6:0]};
            else           b = utf8s_pkg::lead_mark(n) | {2'b00, grp[idx]};
          end else begin
            b = {2'b10, grp[idx]};
          end
        end
        res_o.char_bytes[utf8s_pkg::BytesW-1-8*k -: 8] = b;
      end
    end
  end

endmodule

### hw/rtl/utf8_char_splitter.sv
// channel | dir | tdata                           | tuser  | tlast
// s_axis  | in  | data_byte                       | -      | end_of_string
// m_axis  | out | code_point, byte_count, bytes   | status | -
//
// One byte per cycle while the output is not stalled: decode and canonical re-encoding sit
// between the input handshake and a single output register, so each result is registered.
// Reset clears the sequence state and the output valid.
// A stalled output holds in its register; input is taken while the register
// is empty or being drained in the same cycle.
module utf8_char_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // [30:0] code_point, [33:31] byte_count,
                                     // [81:34] char_bytes, [87:82] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  utf8s_pkg::dec_t dec;
  utf8s_pkg::res_t res;
  utf8s_pkg::res_t res_q;
  logic            vld_q;
  logic            in_acc;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  utf8s_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .data_byte_i (s_axis_tdata),
    .eos_i       (s_axis_tlast),
    .dec_o       (dec)
  );

  utf8s_encode u_encode (
    .dec_i (dec),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      vld_q <= in_acc && dec.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && dec.vld) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {6'd0, res_q.char_bytes, res_q.byte_count, res_q.code_point};

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != utf8s_pkg::StChar |-> m_axis_tdata == '0)
    else $error("error word carries payload");

  a_char_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == utf8s_pkg::StChar |->
      m_axis_tdata[33:31] != 3'd0 && m_axis_tdata[33:31] <= 3'd6)
    else $error("character word with bad byte count");

  a_ascii_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == utf8s_pkg::StChar && m_axis_tdata[33:31] == 3'd1
      |-> !m_axis_tdata[81] && m_axis_tdata[73:34] == '0)
    else $error("single-byte character not in plain form");

endmodule

### tb/utf8_char_splitter_tb.sv
module utf8_char_splitter_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;   // [30:0] code_point, [33:31] byte_count,
                               // [81:34] char_bytes, [87:82] zero
  logic [1:0]  m_axis_tuser;   // [1:0] status

  utf8_char_splitter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  typedef struct {
    logic [7:0]      data;
    logic            last;
    bit              typed;
    utf8s_pkg::res_t want;
  } dir_row_t;

  // typed rows carry their expected word, the rest go through the decoder model
  dir_row_t dir_tab [26] = '{
    '{8'h00, 1'b0, 1'b1, '{utf8s_pkg::StChar, 31'h0, 3'd1, 48'h0}},
    '{8'h7f, 1'b1, 1'b1, '{utf8s_pkg::StChar, 31'h7f, 3'd1, 48'h7f00_0000_0000}},
    '{8'h80, 1'b0, 1'b1, '{utf8s_pkg::StContLead, 31'h0, 3'd0, 48'h0}},
    '{8'h41, 1'b1, 1'b0, '0},
    '{8'hc3, 1'b0, 1'b0, '0},
    '{8'ha9, 1'b1, 1'b0, '0},
    '{8'he2, 1'b0, 1'b0, '0},
    '{8'h82, 1'b0, 1'b0, '0},
    '{8'hac, 1'b1, 1'b0, '0},
    '{8'hc0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b1, 1'b1, '{utf8s_pkg::StChar, 31'h7fff_ffff, 3'd6, 48'hfdbf_bfbf_bfbf}},
    '{8'he2, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b1, '{utf8s_pkg::StBadCont, 31'h0, 3'd0, 48'h0}},
    '{8'h42, 1'b1, 1'b0, '0},
    '{8'hc3, 1'b1, 1'b1, '{utf8s_pkg::StTrunc, 31'h0, 3'd0, 48'h0}},
    '{8'he2, 1'b0, 1'b0, '0},
    '{8'h82, 1'b1, 1'b1, '{utf8s_pkg::StTrunc, 31'h0, 3'd0, 48'h0}},
    '{8'hc3, 1'b0, 1'b0, '0},
    '{8'hc3, 1'b1, 1'b1, '{utf8s_pkg::StBadCont, 31'h0, 3'd0, 48'h0}},
    '{8'h24, 1'b1, 1'b0, '0}
  };

  // decoder model state
  logic [2:0]  pend_cont;
  logic [30:0] code_acc;
  bit          dropping;

  utf8s_pkg::res_t want_q [$];
  logic [7:0]      str_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_req;
  bit          hold_taken;
  int unsigned hold_left;

  int unsigned bytes_in;
  int unsigned bytes_used;
  int unsigned strings_sent;
  int unsigned chars_out;
  int unsigned errs_out;
  int unsigned fail_cnt;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic utf8s_pkg::res_t encode_char(input logic [30:0] cp);
    utf8s_pkg::res_t r;
    int unsigned     n;
    logic [7:0]      lead;
    n = (cp < 31'h80) ? 1 : (cp < utf8s_pkg::Lim2) ? 2 : (cp < utf8s_pkg::Lim3) ? 3 :
        (cp < utf8s_pkg::Lim4) ? 4 : (cp < utf8s_pkg::Lim5) ? 5 : 6;
    lead = (n == 1) ? 8'h00 : 8'(8'hff << (8 - n));
    r = '0;
    r.status     = utf8s_pkg::StChar;
    r.code_point = cp;
    r.byte_count = 3'(n);
    for (int k = 0; k < 6; k++) begin
      if (k == 0)
        r.char_bytes[47 -: 8] = 8'(cp >> (6 * (n - 1))) | lead;
      else if (k < n)
        r.char_bytes[47 - 8 * k -: 8] = {2'b10, 6'(cp >> (6 * (n - 1 - k)))};
    end
    return r;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output utf8s_pkg::res_t r);
    bit          hit;
    int unsigned cnt;
    hit = 1'b0;
    r   = '0;
    if (dropping) begin
      if (eos) begin
        pend_cont = '0;
        code_acc  = '0;
        dropping  = 1'b0;
      end
      return 1'b0;
    end
    if (pend_cont == 0) begin
      if (!b[7]) begin
        r   = encode_char({23'd0, b});
        hit = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        r.status = utf8s_pkg::StContLead;
        hit      = 1'b1;
        dropping = 1'b1;
      end else begin
        cnt = int'(b >= 8'hc0) + int'(b >= 8'he0) + int'(b >= 8'hf0) +
              int'(b >= 8'hf8) + int'(b >= 8'hfc);
        pend_cont = 3'(cnt);
        code_acc  = 31'(b & ((8'd1 << (6 - cnt)) - 8'd1));
        if (eos) begin
          r.status = utf8s_pkg::StTrunc;
          hit      = 1'b1;
        end
      end
    end else if (b[7:6] != 2'b10) begin
      r.status = utf8s_pkg::StBadCont;
      hit      = 1'b1;
      dropping = 1'b1;
    end else begin
      code_acc  = {code_acc[24:0], b[5:0]};
      pend_cont = pend_cont - 3'd1;
      if (pend_cont == 0) begin
        r        = encode_char(code_acc);
        hit      = 1'b1;
        code_acc = '0;
      end else if (eos) begin
        r.status = utf8s_pkg::StTrunc;
        hit      = 1'b1;
      end
    end
    if (eos) begin
      pend_cont = '0;
      code_acc  = '0;
      dropping  = 1'b0;
    end
    return hit;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eos, input bit typed,
                           input utf8s_pkg::res_t want);
    utf8s_pkg::res_t r;
    bit              hit;
    bit              was_dropping;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    was_dropping = dropping;
    hit = decode_byte(b, eos, r);
    if (typed) want_q.insert(want_q.size(), want);
    else if (hit) want_q.insert(want_q.size(), r);
    if (!was_dropping) bytes_used++;
    bytes_in++;
  endtask

  task automatic add_char();
    int unsigned cls;
    int unsigned len;
    logic [30:0] cp;
    logic [7:0]  lead;
    cls = ($urandom_range(99) < 45) ? 1 : $urandom_range(2, 6);
    case (cls)
      1:       cp = 31'($urandom_range(32'h0, 32'h7f));
      2:       cp = 31'($urandom_range(32'h80, 32'h7ff));
      3:       cp = 31'($urandom_range(32'h800, 32'hffff));
      4:       cp = 31'($urandom_range(32'h1_0000, 32'h1f_ffff));
      5:       cp = 31'($urandom_range(32'h20_0000, 32'h3ff_ffff));
      default: cp = 31'($urandom_range(32'h400_0000, 32'h7fff_ffff));
    endcase
    // overlong forms now and then
    len = ($urandom_range(99) < 20) ? $urandom_range(cls, 6) : cls;
    if (len == 1) begin
      str_q.insert(str_q.size(), {1'b0, cp[6:0]});
    end else begin
      lead = 8'(8'hff << (8 - len)) | 8'(cp >> (6 * (len - 1)));
      // 0xfe/0xff leads decode like 0xfc/0xfd
      if (len == 6 && $urandom_range(3) == 0) lead[1] = 1'b1;
      str_q.insert(str_q.size(), lead);
      for (int k = int'(len) - 2; k >= 0; k--)
        str_q.insert(str_q.size(), {2'b10, 6'(cp >> (6 * k))});
    end
  endtask

  task automatic send_strings(input int unsigned target);
    int unsigned kind;
    int unsigned idx;
    int unsigned stop_at;
    stop_at = bytes_in + target;
    while (bytes_in < stop_at) begin
      str_q.delete();
      kind = $urandom_range(99);
      if (kind < 92) begin
        repeat ($urandom_range(1, 8)) add_char();
        if (kind >= 76) begin
          idx = $urandom_range(str_q.size() - 1);
          if ($urandom_range(1)) begin
            str_q[idx] = 8'($urandom);
          end else begin
            while (str_q.size() > idx + 1) void'(str_q.pop_back());
          end
        end
      end else begin
        repeat ($urandom_range(1, 10)) str_q.insert(str_q.size(), 8'($urandom));
      end
      for (int i = 0; i < str_q.size(); i++)
        send_word(str_q[i], i == str_q.size() - 1, 1'b0, '0);
      strings_sent++;
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    hold_req      <= 1'b0;
    pend_cont     = '0;
    code_acc      = '0;
    dropping      = 1'b0;
    bytes_in      = 0;
    bytes_used    = 0;
    strings_sent  = 0;
    send_idle_pct = 23;
    recv_idle_pct = 59;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_word(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

    send_strings(600);
    send_idle_pct = 59;
    recv_idle_pct = 23;
    send_strings(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold-off while bytes keep coming
    hold_req <= 1'b1;
    send_strings(600);
    s_axis_tvalid <= 1'b0;

    while (want_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes in %0d strings (%0d decoded, rest dropped after errors)",
             bytes_in, strings_sent, bytes_used);
    $display("Checked %0d character words and %0d error words, %0d mismatches",
             chars_out, errs_out, fail_cnt);
    if (fail_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    m_axis_tready <= 1'b0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 250;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    chars_out = 0;
    errs_out  = 0;
    fail_cnt  = 0;
  end

  always @(posedge clk_i) begin
    utf8s_pkg::res_t got;
    utf8s_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = utf8s_pkg::status_e'(m_axis_tuser);
      got.code_point = m_axis_tdata[30:0];
      got.byte_count = m_axis_tdata[33:31];
      got.char_bytes = m_axis_tdata[81:34];
      if (got.status == utf8s_pkg::StChar) chars_out++;
      else errs_out++;
      if (want_q.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected word: st=%0d cp=%h n=%0d bytes=%h", got.status,
                   got.code_point, got.byte_count, got.char_bytes);
        fail_cnt++;
      end else begin
        want = want_q.pop_front();
        if (got.status !== want.status || got.code_point !== want.code_point ||
            got.byte_count !== want.byte_count || got.char_bytes !== want.char_bytes) begin
          if (fail_cnt < 10)
            $display("mismatch: exp st=%0d cp=%h n=%0d bytes=%h, got st=%0d cp=%h n=%0d bytes=%h",
                     want.status, want.code_point, want.byte_count, want.char_bytes,
                     got.status, got.code_point, got.byte_count, got.char_bytes);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #(12 * 300000);
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/utf8s_pkg.sv
hw/rtl/utf8s_decode.sv
hw/rtl/utf8s_encode.sv
hw/rtl/utf8_char_splitter.sv
tb/utf8_char_splitter_tb.sv
